// File: rtl/hpte_pkg.sv
// ----------------------------------------------------------------------------
// hpte_pkg
// Shared types and constants for the hashed page table engine.
// ----------------------------------------------------------------------------
package hpte_pkg;

  localparam int unsigned NUM_GROUPS = 2048;
  localparam int unsigned WAYS       = 8;
  localparam int unsigned GRP_W      = $clog2(NUM_GROUPS);
  localparam int unsigned WAY_W      = $clog2(WAYS);
  localparam int unsigned SLOT_W     = GRP_W + WAY_W;

  localparam logic [63:0] F_VALID   = 64'h1;
  localparam logic [63:0] F_HID     = 64'h2;
  localparam logic [63:0] F_BIG     = 64'h4;
  localparam logic [63:0] F_LOCKED  = 64'h8;
  localparam logic [63:0] F_WIRED   = 64'h10;
  localparam logic [63:0] AVPN_MASK = 64'hffff_ffff_ffff_ff80;
  localparam logic [63:0] RC_MASK   = 64'h180;
  localparam logic [63:0] REFB_MASK = 64'hff00;
  localparam logic [63:0] HASH_MASK = 64'h0000_007f_ffff_ffff;
  localparam logic [63:0] HIGH_HALF = 64'hffff_ffff_0000_0000;
  localparam logic [63:0] FREE_MASK = F_VALID | F_WIRED | F_LOCKED;
  localparam logic [63:0] EVCT_MASK = F_WIRED | F_LOCKED;

  localparam logic [2:0] CMD_INSERT  = 3'd0;
  localparam logic [2:0] CMD_READ_RC = 3'd1;
  localparam logic [2:0] CMD_CLR_REF = 3'd2;
  localparam logic [2:0] CMD_UNSET   = 3'd3;
  localparam logic [2:0] CMD_REPLACE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic CFG_GROUP_MASK = 1'b0;
  localparam logic CFG_LP_SHIFT   = 1'b1;

  typedef logic [WAYS-1:0][63:0] row_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD_A, S_CAP_A, S_CAP_B, S_PROBE, S_EXEC, S_OUT
  } state_t;

endpackage

// File: rtl/hashed_page_table_engine_unit.sv
// ----------------------------------------------------------------------------
// hashed_page_table_engine_unit
// Hashed page table of eight-way groups: insert with probe/evict, R/C read,
// clear reference, unset and soft replace, one shared probe unit.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tdata (216 bits)
// out_     out  out_tvalid/out_tready  out_tdata (152 bits)
// cfg_     in   cfg_wr_en              cfg_addr, cfg_wdata
//
// After reset a clearing pass writes one group row a cycle, all 2048 groups.
// Insert: two group row reads, up to four probe steps of the shared probe
// unit, and a write on a hit. Other commands: one row read.
// A stalled out_tready holds the finished result; the next transfer is
// taken once the result is loaded into the output register.
// ----------------------------------------------------------------------------
module hashed_page_table_engine_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[2:0] slot_index[16:3] start_offset[19:17] entry_high[83:20]
  // entry_low[147:84] page_vpn[211:148] zero[215:212]
  input  logic [215:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0] result_slot[15:2] used_secondary[16] value_low[80:17]
  // invalidate_valid[81] invalidate_vpn[145:82] zero[151:146]
  output logic [151:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic         cfg_addr,
  input  logic [10:0]  cfg_wdata
);

  localparam int unsigned GW = hpte_pkg::GRP_W;
  localparam int unsigned WW = hpte_pkg::WAY_W;
  localparam int unsigned SW = hpte_pkg::SLOT_W;

  hpte_pkg::row_t hi_mem [hpte_pkg::NUM_GROUPS];
  hpte_pkg::row_t lo_mem [hpte_pkg::NUM_GROUPS];

  hpte_pkg::state_t state_r, state_nxt;
  logic [GW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [2:0]    cmd_r;
  logic [SW-1:0] slot_r;
  logic [WW-1:0] start_r;
  logic [63:0]   ehi_r, elo_r, vpn_r;
  logic [10:0]   gmask_r;
  logic [5:0]    lps_r;
  hpte_pkg::row_t rd_hi_r, rd_lo_r;
  hpte_pkg::row_t row_a_hi_r, row_a_lo_r, row_b_hi_r, row_b_lo_r;
  logic [1:0]    step_r, step_nxt;

  logic [1:0]    res_status_r, res_status_nxt;
  logic [SW-1:0] res_slot_r, res_slot_nxt;
  logic          res_sec_r, res_sec_nxt;
  logic [63:0]   res_vlow_r, res_vlow_nxt;
  logic          res_inv_r, res_inv_nxt;
  logic [63:0]   res_ivpn_r, res_ivpn_nxt;

  logic          out_valid_r;
  logic [1:0]    o_status_r;
  logic [SW-1:0] o_slot_r;
  logic          o_sec_r;
  logic [63:0]   o_vlow_r;
  logic          o_inv_r;
  logic [63:0]   o_ivpn_r;

  logic [GW-1:0] grp_a, grp_b, rd_addr, wr_addr;
  logic          wr_en;
  hpte_pkg::row_t wr_hi, wr_lo;
  logic          accept, load_out;

  // shared probe unit
  hpte_pkg::row_t probe_row;
  logic [63:0]   probe_mask;
  logic          probe_hit;
  logic [WW-1:0] probe_way;
  logic          use_b;

  assign grp_a = slot_r[SW-1:WW];
  assign grp_b = grp_a ^ gmask_r[GW-1:0];
  assign use_b = step_r[0] ^ step_r[1];
  assign probe_row  = use_b ? row_b_hi_r : row_a_hi_r;
  assign probe_mask = step_r[1] ? hpte_pkg::EVCT_MASK : hpte_pkg::FREE_MASK;

  always_comb begin
    logic [WW-1:0] k;
    probe_hit = 1'b0;
    probe_way = '0;
    for (int j = 0; j < hpte_pkg::WAYS; j++) begin
      k = start_r + WW'(j);
      if (!probe_hit && ((probe_row[k] & probe_mask) == 64'd0)) begin
        probe_hit = 1'b1;
        probe_way = k;
      end
    end
  end

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == hpte_pkg::S_IDLE);
  assign load_out  = (state_r == hpte_pkg::S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    logic [63:0] old_hi, old_lo, va, grp64;
    logic        tag_ok;
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_sec_nxt    = res_sec_r;
    res_vlow_nxt   = res_vlow_r;
    res_inv_nxt    = res_inv_r;
    res_ivpn_nxt   = res_ivpn_r;
    rd_addr        = grp_a;
    wr_en          = 1'b0;
    wr_addr        = grp_a;
    wr_hi          = row_a_hi_r;
    wr_lo          = row_a_lo_r;
    old_hi         = row_a_hi_r[slot_r[WW-1:0]];
    old_lo         = row_a_lo_r[slot_r[WW-1:0]];
    va             = '0;
    grp64          = '0;
    tag_ok         = ((old_hi & hpte_pkg::AVPN_MASK) == (ehi_r & hpte_pkg::AVPN_MASK));
    case (state_r)
      hpte_pkg::S_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_hi       = '0;
        wr_lo       = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) state_nxt = hpte_pkg::S_IDLE;
      end
      hpte_pkg::S_IDLE: begin
        if (accept) state_nxt = hpte_pkg::S_RD_A;
      end
      hpte_pkg::S_RD_A: begin
        state_nxt = hpte_pkg::S_CAP_A;
      end
      hpte_pkg::S_CAP_A: begin
        rd_addr        = grp_b;
        step_nxt       = 2'd0;
        res_status_nxt = hpte_pkg::ST_OK;
        res_slot_nxt   = '0;
        res_sec_nxt    = 1'b0;
        res_vlow_nxt   = '0;
        res_inv_nxt    = 1'b0;
        res_ivpn_nxt   = '0;
        state_nxt = (cmd_r == hpte_pkg::CMD_INSERT) ? hpte_pkg::S_CAP_B : hpte_pkg::S_EXEC;
      end
      hpte_pkg::S_CAP_B: begin
        state_nxt = hpte_pkg::S_PROBE;
      end
      hpte_pkg::S_PROBE: begin
        if (probe_hit) begin
          old_hi = probe_row[probe_way];
          grp64  = {{(64-GW){1'b0}}, use_b ? grp_b : grp_a};
          if ((old_hi & hpte_pkg::F_HID) != 64'd0) grp64 = grp64 ^ {53'd0, gmask_r};
          va = ((old_hi & hpte_pkg::F_BIG) != 64'd0) ? (old_hi >> lps_r) : (old_hi >> 12);
          va = ((grp64 ^ va) & hpte_pkg::HASH_MASK) | ((old_hi & hpte_pkg::AVPN_MASK) << 4);
          res_inv_nxt  = ((old_hi & hpte_pkg::F_VALID) != 64'd0);
          res_ivpn_nxt = ((old_hi & hpte_pkg::F_VALID) != 64'd0) ? va : 64'd0;
          res_slot_nxt = {use_b ? grp_b : grp_a, probe_way};
          res_sec_nxt  = use_b;
          wr_en   = 1'b1;
          wr_addr = use_b ? grp_b : grp_a;
          wr_hi   = probe_row;
          wr_lo   = use_b ? row_b_lo_r : row_a_lo_r;
          wr_hi[probe_way] = use_b ? (ehi_r ^ hpte_pkg::F_HID) : ehi_r;
          wr_lo[probe_way] = elo_r;
          state_nxt = hpte_pkg::S_OUT;
        end else if (step_r == 2'd3) begin
          res_status_nxt = hpte_pkg::ST_OVERFLOW;
          state_nxt      = hpte_pkg::S_OUT;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      hpte_pkg::S_EXEC: begin
        state_nxt = hpte_pkg::S_OUT;
        if (cmd_r <= hpte_pkg::CMD_REPLACE) begin
          if (!tag_ok) begin
            res_status_nxt = hpte_pkg::ST_MISMATCH;
          end else begin
            case (cmd_r)
              hpte_pkg::CMD_READ_RC: begin
                res_vlow_nxt = old_lo & hpte_pkg::RC_MASK;
              end
              hpte_pkg::CMD_CLR_REF: begin
                res_vlow_nxt = old_lo & hpte_pkg::RC_MASK;
                res_inv_nxt  = 1'b1;
                res_ivpn_nxt = vpn_r;
                wr_en        = 1'b1;
                wr_lo[slot_r[WW-1:0]] = (old_lo & ~hpte_pkg::REFB_MASK) |
                                        (elo_r & hpte_pkg::REFB_MASK);
              end
              hpte_pkg::CMD_UNSET: begin
                res_vlow_nxt = old_lo & hpte_pkg::RC_MASK;
                res_inv_nxt  = 1'b1;
                res_ivpn_nxt = vpn_r;
                wr_en        = 1'b1;
                wr_hi[slot_r[WW-1:0]] = old_hi & hpte_pkg::HIGH_HALF;
              end
              hpte_pkg::CMD_REPLACE: begin
                res_vlow_nxt = old_lo;
                wr_en        = 1'b1;
                wr_hi[slot_r[WW-1:0]] = ehi_r;
              end
              default: begin
              end
            endcase
          end
        end
      end
      hpte_pkg::S_OUT: begin
        if (load_out) state_nxt = hpte_pkg::S_IDLE;
      end
      default: state_nxt = hpte_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_hi_r <= hi_mem[rd_addr];
    rd_lo_r <= lo_mem[rd_addr];
    if (wr_en) begin
      hi_mem[wr_addr] <= wr_hi;
      lo_mem[wr_addr] <= wr_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpte_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      gmask_r     <= 11'd2047;
      lps_r       <= 6'd24;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      step_r    <= step_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_wr_en && cfg_addr == hpte_pkg::CFG_GROUP_MASK) gmask_r <= cfg_wdata;
      if (cfg_wr_en && cfg_addr == hpte_pkg::CFG_LP_SHIFT) lps_r <= cfg_wdata[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_tdata[2:0];
      slot_r  <= in_tdata[16:3];
      start_r <= in_tdata[19:17];
      ehi_r   <= in_tdata[83:20];
      elo_r   <= in_tdata[147:84];
      vpn_r   <= in_tdata[211:148];
    end
    if (state_r == hpte_pkg::S_CAP_A) begin
      row_a_hi_r <= rd_hi_r;
      row_a_lo_r <= rd_lo_r;
    end
    if (state_r == hpte_pkg::S_CAP_B) begin
      row_b_hi_r <= rd_hi_r;
      row_b_lo_r <= rd_lo_r;
    end
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_sec_r    <= res_sec_nxt;
    res_vlow_r   <= res_vlow_nxt;
    res_inv_r    <= res_inv_nxt;
    res_ivpn_r   <= res_ivpn_nxt;
    if (load_out) begin
      o_status_r <= res_status_r;
      o_slot_r   <= res_slot_r;
      o_sec_r    <= res_sec_r;
      o_vlow_r   <= res_vlow_r;
      o_inv_r    <= res_inv_r;
      o_ivpn_r   <= res_ivpn_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, o_ivpn_r, o_inv_r, o_vlow_r, o_sec_r, o_slot_r, o_status_r};

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hpte_pkg::S_CLEAR |-> !in_tready)
    else $error("input taken during clearing pass");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == hpte_pkg::S_CLEAR || state_r == hpte_pkg::S_PROBE ||
               state_r == hpte_pkg::S_EXEC))
    else $error("table write outside write states");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> o_status_r != 2'd3)
    else $error("undefined status code");

  a_probe_from_cap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == hpte_pkg::S_PROBE) |-> $past(state_r) == hpte_pkg::S_CAP_B &&
                                            step_r == 2'd0)
    else $error("probe started without both group rows");

endmodule
